@@ hdl/cws_pkg.sv @@
// Shared constants, types and the sequencer state encoding for the centered window sum block.
// Used by cws_cell, cws_range and centered_window_sum_with_range.
package cws_pkg;

   localparam int MAX_RADIUS    = 31;
   localparam int SAMPLE_BITS   = 32;
   localparam int INDEX_BITS    = 20;
   localparam int RADIUS_BITS   = 5;
   localparam int SUM_BITS      = 38;
   localparam int POSITION_BITS = 20;
   localparam int RADIUS_RESET  = 1;
   localparam int RADIUS_CAP    = (MAX_RADIUS < 31) ? MAX_RADIUS : 31;
   localparam int CHAIN_DEPTH   = 2 * RADIUS_CAP + 1;
   localparam int ENTRY_BITS    = $clog2(CHAIN_DEPTH);

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_RUN,
      SEQ_FLUSH
   } seq_state_type;

   typedef struct packed {
      logic                   valid;
      logic [SAMPLE_BITS-1:0] data;
   } cell_type;

   typedef struct packed {
      logic                   shift;
      logic                   clear;
      logic                   fill;
      logic [SAMPLE_BITS-1:0] data;
   } chain_ctrl_type;

   typedef struct packed {
      logic [POSITION_BITS-1:0] position;
      logic [SUM_BITS-1:0]      window_sum;
      logic                     last;
   } give_type;

endpackage

@@ hdl/cws_cell.sv @@
// One sample cell of the window delay chain: loads the new sample at the entry point,
// otherwise takes its upper neighbor on each shift. Depends on cws_pkg.
module cws_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  cws_pkg::chain_ctrl_type ctrl,
   input  logic                    is_entry,
   input  cws_pkg::cell_type       upper,
   output cws_pkg::cell_type       held
);

   logic                            valid_ff;
   logic                            valid_in;
   logic [cws_pkg::SAMPLE_BITS-1:0] data_ff;
   logic [cws_pkg::SAMPLE_BITS-1:0] data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         if (is_entry) begin
            valid_in = ctrl.fill;
            data_in  = ctrl.data;
         end else begin
            valid_in = upper.valid;
            data_in  = upper.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign held = {valid_ff, data_ff};

endmodule

@@ hdl/cws_range.sv @@
// Result stage: tracks the running min and max of window sums and holds the result register.
// Depends on cws_pkg.
module cws_range (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                give_valid,
   output logic                                give_ready,
   input  cws_pkg::give_type                   give,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cws_pkg::POSITION_BITS-1:0]   rsp_position,
   output logic [cws_pkg::SUM_BITS-1:0]        rsp_window_sum,
   output logic [cws_pkg::SUM_BITS-1:0]        rsp_min_sum,
   output logic [cws_pkg::SUM_BITS-1:0]        rsp_max_sum,
   output logic                                rsp_last_result
);

   logic                                rsp_valid_ff;
   logic                                min_valid_ff;
   logic [cws_pkg::SUM_BITS-1:0]        min_ff;
   logic [cws_pkg::SUM_BITS-1:0]        max_ff;
   logic [cws_pkg::SUM_BITS-1:0]        min_in;
   logic [cws_pkg::SUM_BITS-1:0]        max_in;
   logic [cws_pkg::POSITION_BITS-1:0]   position_ff;
   logic [cws_pkg::SUM_BITS-1:0]        sum_ff;
   logic [cws_pkg::SUM_BITS-1:0]        out_min_ff;
   logic [cws_pkg::SUM_BITS-1:0]        out_max_ff;
   logic                                last_ff;
   logic                                load;

   assign give_ready = !rsp_valid_ff || rsp_ready;
   assign load       = give_valid && give_ready;

   always_comb begin
      min_in = min_ff;
      max_in = max_ff;
      if (!min_valid_ff || (give.window_sum < min_ff)) begin
         min_in = give.window_sum;
      end
      if (give.window_sum > max_ff) begin
         max_in = give.window_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         min_valid_ff <= 1'b0;
         min_ff       <= '0;
         max_ff       <= '0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (load) begin
            if (give.last) begin
               min_valid_ff <= 1'b0;
               min_ff       <= '0;
               max_ff       <= '0;
            end else begin
               min_valid_ff <= 1'b1;
               min_ff       <= min_in;
               max_ff       <= max_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         position_ff <= give.position;
         sum_ff      <= give.window_sum;
         out_min_ff  <= min_in;
         out_max_ff  <= max_in;
         last_ff     <= give.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_position    = position_ff;
   assign rsp_window_sum  = sum_ff;
   assign rsp_min_sum     = out_min_ff;
   assign rsp_max_sum     = out_max_ff;
   assign rsp_last_result = last_ff;

`ifndef SYNTHESIS
   a_range_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_min_ff <= sum_ff) && (sum_ff <= out_max_ff))
      else $error("window sum outside reported range");

   a_range_cleared: assert property (@(posedge clock) disable iff (reset)
      load && give.last |=> !min_valid_ff && (max_ff == '0))
      else $error("range not cleared after final transaction");
`endif

endmodule

@@ hdl/centered_window_sum_with_range.sv @@
// Top level of the centered window sum: sequencer, running sum and the chain of sample cells.
// Depends on cws_pkg, cws_cell and cws_range.
//
//   channel  ports                         direction  content
//   req      req_valid / req_ready         in         sample, end_of_sequence
//   rsp      rsp_valid / rsp_ready         out        position, sums, range, last flag
//   csr      csr_valid / csr_ready         in         radius (always ready)
//
// One sample per cycle unless the chain stalls; each sample shifts the cell chain once and gives at most one result.
// The transaction with end_of_sequence adds radius flush steps (radius + 1 results at most),
// one chain shift each; req_ready is low during the flush.
// A result waits in the output register; the chain stalls only when both result
// registers are full. Synchronous reset clears control state and sets radius to 1.
module centered_window_sum_with_range (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [31:0]                         req_sample,
   input  logic                                req_end_of_sequence,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cws_pkg::POSITION_BITS-1:0]   rsp_position,
   output logic [cws_pkg::SUM_BITS-1:0]        rsp_window_sum,
   output logic [cws_pkg::SUM_BITS-1:0]        rsp_min_sum,
   output logic [cws_pkg::SUM_BITS-1:0]        rsp_max_sum,
   output logic                                rsp_last_result,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [cws_pkg::RADIUS_BITS-1:0]     csr_radius
);

   cws_pkg::seq_state_type              state_ff;
   cws_pkg::seq_state_type              state_in;
   logic [cws_pkg::RADIUS_BITS-1:0]     radius_ff;
   logic [cws_pkg::RADIUS_BITS-1:0]     active_ff;
   logic [cws_pkg::RADIUS_BITS-1:0]     active_in;
   logic [cws_pkg::RADIUS_BITS-1:0]     warm_ff;
   logic [cws_pkg::RADIUS_BITS-1:0]     warm_in;
   logic [cws_pkg::RADIUS_BITS-1:0]     flush_cnt_ff;
   logic [cws_pkg::RADIUS_BITS-1:0]     flush_cnt_in;
   logic [cws_pkg::INDEX_BITS-1:0]      next_pos_ff;
   logic [cws_pkg::INDEX_BITS-1:0]      next_pos_in;
   logic [cws_pkg::SUM_BITS-1:0]        sum_ff;
   logic [cws_pkg::SUM_BITS-1:0]        sum_in;
   logic [cws_pkg::SUM_BITS-1:0]        sum_out;
   logic [cws_pkg::SUM_BITS-1:0]        expire_val;
   logic [cws_pkg::RADIUS_BITS-1:0]     radius_cap;
   logic [cws_pkg::RADIUS_BITS-1:0]     eff_radius;
   logic [cws_pkg::ENTRY_BITS-1:0]      entry;
   logic [cws_pkg::SAMPLE_BITS-1:0]     x;
   logic                                flushing;
   logic                                step_ok;
   logic                                step;
   logic                                give;
   logic                                last;
   logic                                give_valid_ff;
   logic                                give_ready;
   cws_pkg::give_type                   give_ff;
   cws_pkg::chain_ctrl_type             ctrl;
   cws_pkg::cell_type                   cells [cws_pkg::CHAIN_DEPTH];
   cws_pkg::cell_type                   uppers [cws_pkg::CHAIN_DEPTH];
   cws_pkg::cell_type                   expire_cell;
   logic [cws_pkg::CHAIN_DEPTH-1:0]     is_entry;

   // configuration register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= cws_pkg::RADIUS_BITS'(cws_pkg::RADIUS_RESET);
      end else if (csr_valid) begin
         radius_ff <= csr_radius;
      end
   end

   assign radius_cap = (radius_ff > cws_pkg::RADIUS_BITS'(cws_pkg::RADIUS_CAP))
                       ? cws_pkg::RADIUS_BITS'(cws_pkg::RADIUS_CAP) : radius_ff;
   assign flushing   = (state_ff == cws_pkg::SEQ_FLUSH);
   assign eff_radius = (state_ff == cws_pkg::SEQ_IDLE) ? radius_cap : active_ff;
   assign entry      = cws_pkg::ENTRY_BITS'({eff_radius, 1'b0});
   assign x          = flushing ? '0 : cws_pkg::SAMPLE_BITS'(req_sample);
   assign step_ok    = !give_valid_ff || give_ready;
   assign step       = flushing ? step_ok : (req_valid && step_ok);
   assign req_ready  = step_ok && !flushing;

   // sample leaving the window sits in cell 0 after this shift
   always_comb begin
      if (entry == '0) begin
         expire_cell.valid = !flushing;
         expire_cell.data  = x;
      end else begin
         expire_cell = cells[1];
      end
      expire_val = expire_cell.valid ? cws_pkg::SUM_BITS'(expire_cell.data) : '0;
   end

   assign sum_out = sum_ff + cws_pkg::SUM_BITS'(x);

   always_comb begin
      state_in     = state_ff;
      active_in    = active_ff;
      warm_in      = warm_ff;
      flush_cnt_in = flush_cnt_ff;
      next_pos_in  = next_pos_ff;
      sum_in       = sum_ff;
      give         = 1'b0;
      last         = 1'b0;
      if (step) begin
         give = (warm_ff == eff_radius);
         if (!give) begin
            warm_in = warm_ff + 1'b1;
         end
         if (flushing) begin
            last         = give && (flush_cnt_ff == cws_pkg::RADIUS_BITS'(1));
            flush_cnt_in = flush_cnt_ff - 1'b1;
         end else begin
            if (state_ff == cws_pkg::SEQ_IDLE) begin
               active_in = radius_cap;
               state_in  = cws_pkg::SEQ_RUN;
            end
            if (req_end_of_sequence) begin
               if (eff_radius == '0) begin
                  last = give;
               end else begin
                  state_in     = cws_pkg::SEQ_FLUSH;
                  flush_cnt_in = eff_radius;
               end
            end
         end
         sum_in = give ? (sum_out - expire_val) : sum_out;
         if (give) begin
            next_pos_in = next_pos_ff + 1'b1;
         end
         if (last) begin
            state_in     = cws_pkg::SEQ_IDLE;
            sum_in       = '0;
            next_pos_in  = '0;
            warm_in      = '0;
            flush_cnt_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cws_pkg::SEQ_IDLE;
         active_ff    <= '0;
         warm_ff      <= '0;
         flush_cnt_ff <= '0;
         next_pos_ff  <= '0;
         sum_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         active_ff    <= active_in;
         warm_ff      <= warm_in;
         flush_cnt_ff <= flush_cnt_in;
         next_pos_ff  <= next_pos_in;
         sum_ff       <= sum_in;
      end
   end

   // result hand-off register
   always_ff @(posedge clock) begin
      if (reset) begin
         give_valid_ff <= 1'b0;
      end else if (step_ok) begin
         give_valid_ff <= give;
      end
   end

   always_ff @(posedge clock) begin
      if (give) begin
         give_ff.position   <= cws_pkg::POSITION_BITS'(next_pos_ff);
         give_ff.window_sum <= sum_out;
         give_ff.last       <= last;
      end
   end

   // cell chain: new sample enters at cell 2*radius, drains toward cell 0
   assign ctrl.shift = step;
   assign ctrl.clear = last;
   assign ctrl.fill  = !flushing;
   assign ctrl.data  = x;

   genvar gi;
   generate
      for (gi = 0; gi < cws_pkg::CHAIN_DEPTH; gi++) begin : g_chain
         assign is_entry[gi] = (entry == cws_pkg::ENTRY_BITS'(gi));
         if (gi == cws_pkg::CHAIN_DEPTH - 1) begin : g_top
            assign uppers[gi] = '0;
         end else begin : g_mid
            assign uppers[gi] = cells[gi+1];
         end
         cws_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .ctrl     (ctrl),
            .is_entry (is_entry[gi]),
            .upper    (uppers[gi]),
            .held     (cells[gi])
         );
      end
   endgenerate

   cws_range u_range (
      .clock           (clock),
      .reset           (reset),
      .give_valid      (give_valid_ff),
      .give_ready      (give_ready),
      .give            (give_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_position    (rsp_position),
      .rsp_window_sum  (rsp_window_sum),
      .rsp_min_sum     (rsp_min_sum),
      .rsp_max_sum     (rsp_max_sum),
      .rsp_last_result (rsp_last_result)
   );

`ifndef SYNTHESIS
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      last |=> (state_ff == cws_pkg::SEQ_IDLE) && (next_pos_ff == '0) && (sum_ff == '0))
      else $error("sequence state not cleared after final result");

   a_flush_count: assert property (@(posedge clock) disable iff (reset)
      flushing |-> (flush_cnt_ff != '0))
      else $error("flush with no positions left");

   a_warm_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != cws_pkg::SEQ_IDLE) |-> (warm_ff <= active_ff))
      else $error("warm-up count beyond radius");
`endif

endmodule
